@@ rtl/pcbs_pkg.sv @@
`default_nettype none

package pcbs_pkg;

    // Field widths
    localparam int COORD_W  = 16;
    localparam int IDX_W    = 6;
    localparam int T_W      = 17;
    localparam int SEGCNT_W = 5;

    // Shared multiplier operand and product widths
    localparam int MUL_A_W = 33;
    localparam int MUL_B_W = 17;
    localparam int MUL_P_W = MUL_A_W + MUL_B_W;

    // Bernstein weight width (weights reach 2^48)
    localparam int WEIGHT_W = 49;
    localparam int ACC_W    = 64;

    // Command modes
    localparam logic [1:0] MODE_WRITE  = 2'd0;
    localparam logic [1:0] MODE_SAMPLE = 2'd1;
    localparam logic [1:0] MODE_SMOOTH = 2'd2;

    typedef struct packed {
        logic [1:0]               mode;
        logic [IDX_W-1:0]         point_index;
        logic signed [COORD_W-1:0] in_x;
        logic signed [COORD_W-1:0] in_y;
        logic signed [COORD_W-1:0] in_z;
        logic [T_W-1:0]           param_t;
    } cmd_item_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] out_x;
        logic signed [COORD_W-1:0] out_y;
        logic signed [COORD_W-1:0] out_z;
    } result_item_t;

    typedef logic [SEGCNT_W-1:0] cfg_item_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        logic signed [COORD_W-1:0] z;
    } point_t;

    typedef struct packed {
        logic             en;
        logic [IDX_W-1:0] addr;
        point_t           data;
    } wr_req_t;

endpackage

`default_nettype wire

@@ rtl/pcbs_chan_if.sv @@
`default_nettype none

// Valid/ready channel carrying one item per handshake
interface pcbs_chan_if #(
    parameter type payload_t = logic
);
    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

@@ rtl/pcbs_ram.sv @@
`default_nettype none

// Single-port-write, single-port-read RAM with registered read data
module pcbs_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 49
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]              rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

@@ rtl/pcbs_mul.sv @@
`default_nettype none

// Shared unsigned multiplier, product registered
module pcbs_mul (
    input  wire logic                           clk,
    input  wire logic [pcbs_pkg::MUL_A_W-1:0]   a,
    input  wire logic [pcbs_pkg::MUL_B_W-1:0]   b,
    output logic [pcbs_pkg::MUL_P_W-1:0]        prod
);
    import pcbs_pkg::*;

    logic [MUL_P_W-1:0] prod_reg;

    always_ff @(posedge clk)
    begin
        prod_reg <= MUL_P_W'(a) * MUL_P_W'(b);
    end

    assign prod = prod_reg;

endmodule

`default_nettype wire

@@ rtl/pcbs_point_store.sv @@
`default_nettype none

// Control point table: RAM plus per-entry written flags.
// An entry never written reads as its reset point (0, i*256, 0).
module pcbs_point_store #(
    parameter int DEPTH = 49
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire pcbs_pkg::wr_req_t             wr,
    input  wire logic [pcbs_pkg::IDX_W-1:0]    raddr,
    output pcbs_pkg::point_t                   rd
);
    import pcbs_pkg::*;

    localparam int AW = $clog2(DEPTH);

    logic             wr_ok;
    logic [AW-1:0]    wa;
    logic [AW-1:0]    ra;
    logic [DEPTH-1:0] valid_reg;
    logic             rd_valid_reg;
    logic [IDX_W-1:0] rd_idx_reg;
    logic [3*COORD_W-1:0] ram_q;
    point_t           ram_pt;

    // Writes past the table are dropped
    assign wr_ok = wr.en && (32'(wr.addr) < 32'(DEPTH));
    assign wa    = wr.addr[AW-1:0];
    assign ra    = raddr[AW-1:0];

    pcbs_ram #(
        .WIDTH (3 * COORD_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (wr_ok),
        .waddr (wa),
        .wdata (wr.data),
        .raddr (ra),
        .rdata (ram_q)
    );

    // Written flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            if (wr_ok)
            begin
                valid_reg[wa] <= 1'b1;
            end
            rd_valid_reg <= valid_reg[ra];
        end
    end

    always_ff @(posedge clk)
    begin
        rd_idx_reg <= raddr;
    end

    // Substitute the reset point for unwritten entries
    always_comb
    begin
        ram_pt = point_t'(ram_q);
        if (rd_valid_reg)
        begin
            rd = ram_pt;
        end
        else
        begin
            rd.x = '0;
            rd.y = COORD_W'({rd_idx_reg, 8'h00});
            rd.z = '0;
        end
    end

endmodule

`default_nettype wire

@@ rtl/piecewise_cubic_bezier_sampler_core.sv @@
`default_nettype none

// Channel   Dir   Payload                                   Handshake
// cmd       in    mode, point_index, in_x/y/z, param_t      valid/ready
// result    out   out_x, out_y, out_z                       valid/ready
// cfg       in    segment_count                             valid/ready (always ready)
//
// Write: stored on acceptance. Sample: a scale product, six weight products, then
// 24 products through the one shared 33x17 multiplier plus a RAM read per point.
// Smooth: per interior joint, two reads over the single RAM read port, one write.
// Reset clears control state and the per-point written flags; no clearing pass.
// cmd is ready only while idle; a finished result waits in the output
// register, and a sample that completes while it is still held stalls.
module piecewise_cubic_bezier_sampler_core #(
    parameter int MAX_SEGMENTS = 16
) (
    input  wire logic   clk,
    input  wire logic   rst_n,
    pcbs_chan_if.sink   cmd,
    pcbs_chan_if.source result,
    pcbs_chan_if.sink   cfg
);
    import pcbs_pkg::*;

    localparam int POINT_COUNT = 3 * MAX_SEGMENTS + 1;

    localparam logic [4:0] S_IDLE  = 5'd0;
    localparam logic [4:0] S_SCALE = 5'd1;
    localparam logic [4:0] S_SEG   = 5'd2;
    localparam logic [4:0] S_W0    = 5'd3;
    localparam logic [4:0] S_W1    = 5'd4;
    localparam logic [4:0] S_W2    = 5'd5;
    localparam logic [4:0] S_W3    = 5'd6;
    localparam logic [4:0] S_W4    = 5'd7;
    localparam logic [4:0] S_W5    = 5'd8;
    localparam logic [4:0] S_W6    = 5'd9;
    localparam logic [4:0] S_RD    = 5'd10;
    localparam logic [4:0] S_MAC   = 5'd11;
    localparam logic [4:0] S_FIN   = 5'd12;
    localparam logic [4:0] S_EMIT  = 5'd13;
    localparam logic [4:0] S_SM_RJ = 5'd14;
    localparam logic [4:0] S_SM_RP = 5'd15;
    localparam logic [4:0] S_SM_WR = 5'd16;

    localparam logic [T_W-1:0]   ONE_Q16   = T_W'(65536);
    localparam logic [ACC_W-1:0] ACC_ROUND = ACC_W'(1) << 47;

    function automatic logic [COORD_W-1:0] mirror_sat(
        input logic signed [COORD_W-1:0] j,
        input logic signed [COORD_W-1:0] p
    );
        logic signed [COORD_W+1:0] r;
        r = ((COORD_W+2)'(j) <<< 1) - (COORD_W+2)'(p);
        if (r > (COORD_W+2)'(32767))
        begin
            return 16'h7FFF;
        end
        else if (r < -(COORD_W+2)'(32768))
        begin
            return 16'h8000;
        end
        return r[COORD_W-1:0];
    endfunction

    // Control registers
    logic [4:0]          state_reg, state_next;
    logic [SEGCNT_W-1:0] seg_count_reg;
    logic [1:0]          k_reg, k_next;
    logic [1:0]          c_reg, c_next;
    logic                h_reg, h_next;
    logic                acc_en_reg, acc_en_next;
    logic [1:0]          acc_c_reg, acc_c_next;
    logic                acc_h_reg, acc_h_next;
    logic                res_valid_reg, res_valid_next;
    logic [SEGCNT_W-1:0] i_reg, i_next;

    // Payload registers
    logic [T_W-1:0]      t_reg, t_next;
    logic [SEGCNT_W-1:0] seg_reg, seg_next;
    logic [IDX_W-1:0]    base_reg, base_next;
    logic [T_W-1:0]      u_reg, u_next;
    logic [T_W-1:0]      v_reg, v_next;
    logic [MUL_A_W-1:0]  vv_reg, vv_next;
    logic [MUL_A_W-1:0]  uu_reg, uu_next;
    logic [WEIGHT_W-1:0] w_reg [4];
    logic [WEIGHT_W-1:0] w_next [4];
    logic [ACC_W-1:0]    acc_reg [3];
    logic                acc_init;
    result_item_t        res_reg, res_next;
    logic [IDX_W-1:0]    jidx_reg, jidx_next;
    point_t              joint_reg, joint_next;

    // Datapath wiring
    logic                cmd_acc;
    logic [SEGCNT_W-1:0] n_eff;
    logic [SEGCNT_W-1:0] n_m1;
    logic [MUL_A_W-1:0]  mul_a;
    logic [MUL_B_W-1:0]  mul_b;
    logic [MUL_P_W-1:0]  prod;
    logic [21:0]         scaled;
    logic [5:0]          seg_raw;
    logic [SEGCNT_W-1:0] seg_c;
    logic [MUL_P_W-1:0]  prod3;
    logic [COORD_W-1:0]  coord_sel;
    logic [WEIGHT_W-1:0] w_cur;
    wr_req_t             store_wr;
    logic [IDX_W-1:0]    raddr;
    point_t              rd;

    assign cmd_acc    = cmd.valid && cmd.ready;
    assign cmd.ready  = (state_reg == S_IDLE);
    assign cfg.ready  = 1'b1;
    assign result.valid   = res_valid_reg;
    assign result.payload = res_reg;

    // Effective segment count
    always_comb
    begin
        if (seg_count_reg == '0)
        begin
            n_eff = SEGCNT_W'(1);
        end
        else if (seg_count_reg > SEGCNT_W'(MAX_SEGMENTS))
        begin
            n_eff = SEGCNT_W'(MAX_SEGMENTS);
        end
        else
        begin
            n_eff = seg_count_reg;
        end
    end
    assign n_m1 = n_eff - SEGCNT_W'(1);

    pcbs_mul u_mul (
        .clk  (clk),
        .a    (mul_a),
        .b    (mul_b),
        .prod (prod)
    );

    pcbs_point_store #(
        .DEPTH (POINT_COUNT)
    ) u_store (
        .clk   (clk),
        .rst_n (rst_n),
        .wr    (store_wr),
        .raddr (raddr),
        .rd    (rd)
    );

    // Segment split of the scaled parameter
    assign scaled  = prod[21:0];
    assign seg_raw = scaled[21:16];
    assign seg_c   = (seg_raw > 6'(n_m1)) ? n_m1 : seg_raw[4:0];
    assign prod3   = prod + (prod << 1);

    // Operand selection for the multiply-accumulate phase
    assign w_cur = w_reg[k_reg];
    always_comb
    begin
        case (c_reg)
            2'd0:    coord_sel = rd.x;
            2'd1:    coord_sel = rd.y;
            default: coord_sel = rd.z;
        endcase
    end

    // Sequencer
    always_comb
    begin
        state_next     = state_reg;
        k_next         = k_reg;
        c_next         = c_reg;
        h_next         = h_reg;
        acc_en_next    = 1'b0;
        acc_c_next     = acc_c_reg;
        acc_h_next     = acc_h_reg;
        i_next         = i_reg;
        t_next         = t_reg;
        seg_next       = seg_reg;
        base_next      = base_reg;
        u_next         = u_reg;
        v_next         = v_reg;
        vv_next        = vv_reg;
        uu_next        = uu_reg;
        for (int n = 0; n < 4; n++)
        begin
            w_next[n] = w_reg[n];
        end
        acc_init       = 1'b0;
        res_next       = res_reg;
        res_valid_next = res_valid_reg;
        jidx_next      = jidx_reg;
        joint_next     = joint_reg;
        mul_a          = '0;
        mul_b          = '0;
        store_wr       = '0;
        raddr          = base_reg + IDX_W'(k_reg);

        if (res_valid_reg && result.ready)
        begin
            res_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (cmd_acc)
                begin
                    case (cmd.payload.mode)
                        MODE_WRITE:
                        begin
                            store_wr.en     = 1'b1;
                            store_wr.addr   = cmd.payload.point_index;
                            store_wr.data.x = cmd.payload.in_x;
                            store_wr.data.y = cmd.payload.in_y;
                            store_wr.data.z = cmd.payload.in_z;
                        end
                        MODE_SAMPLE:
                        begin
                            t_next     = (cmd.payload.param_t > ONE_Q16) ? ONE_Q16
                                                                         : cmd.payload.param_t;
                            acc_init   = 1'b1;
                            state_next = S_SCALE;
                        end
                        MODE_SMOOTH:
                        begin
                            if (n_eff > SEGCNT_W'(1))
                            begin
                                i_next     = SEGCNT_W'(1);
                                jidx_next  = IDX_W'(3);
                                state_next = S_SM_RJ;
                            end
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end
            S_SCALE:
            begin
                mul_a      = MUL_A_W'(t_reg);
                mul_b      = MUL_B_W'(n_eff);
                state_next = S_SEG;
            end
            S_SEG:
            begin
                seg_next   = seg_c;
                base_next  = IDX_W'(seg_c) + (IDX_W'(seg_c) << 1);
                u_next     = T_W'(scaled - 22'({seg_c, 16'h0000}));
                v_next     = ONE_Q16 - T_W'(scaled - 22'({seg_c, 16'h0000}));
                k_next     = '0;
                state_next = S_W0;
            end
            S_W0:
            begin
                mul_a      = MUL_A_W'(v_reg);
                mul_b      = v_reg;
                state_next = S_W1;
            end
            S_W1:
            begin
                vv_next    = prod[MUL_A_W-1:0];
                mul_a      = MUL_A_W'(u_reg);
                mul_b      = u_reg;
                state_next = S_W2;
            end
            S_W2:
            begin
                uu_next    = prod[MUL_A_W-1:0];
                mul_a      = vv_reg;
                mul_b      = v_reg;
                state_next = S_W3;
            end
            S_W3:
            begin
                w_next[0]  = prod[WEIGHT_W-1:0];
                mul_a      = vv_reg;
                mul_b      = u_reg;
                state_next = S_W4;
            end
            S_W4:
            begin
                w_next[1]  = prod3[WEIGHT_W-1:0];
                mul_a      = uu_reg;
                mul_b      = v_reg;
                state_next = S_W5;
            end
            S_W5:
            begin
                w_next[2]  = prod3[WEIGHT_W-1:0];
                mul_a      = uu_reg;
                mul_b      = u_reg;
                state_next = S_W6;
            end
            S_W6:
            begin
                // First point's read has been running since the base settled
                w_next[3]  = prod[WEIGHT_W-1:0];
                c_next     = '0;
                h_next     = 1'b0;
                state_next = S_MAC;
            end
            S_RD:
            begin
                state_next = S_MAC;
            end
            S_MAC:
            begin
                // One half-weight by one biased coordinate per cycle
                mul_a       = h_reg ? MUL_A_W'(w_cur[WEIGHT_W-1:32]) : MUL_A_W'(w_cur[31:0]);
                mul_b       = {1'b0, coord_sel ^ 16'h8000};
                acc_en_next = 1'b1;
                acc_c_next  = c_reg;
                acc_h_next  = h_reg;
                h_next      = !h_reg;
                if (h_reg)
                begin
                    if (c_reg == 2'd2)
                    begin
                        c_next = '0;
                        if (k_reg == 2'd3)
                        begin
                            state_next = S_FIN;
                        end
                        else
                        begin
                            k_next     = k_reg + 2'd1;
                            state_next = S_RD;
                        end
                    end
                    else
                    begin
                        c_next = c_reg + 2'd1;
                    end
                end
            end
            S_FIN:
            begin
                state_next = S_EMIT;
            end
            S_EMIT:
            begin
                if (!res_valid_reg || result.ready)
                begin
                    res_next.out_x = acc_reg[0][63:48] ^ 16'h8000;
                    res_next.out_y = acc_reg[1][63:48] ^ 16'h8000;
                    res_next.out_z = acc_reg[2][63:48] ^ 16'h8000;
                    res_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            S_SM_RJ:
            begin
                raddr      = jidx_reg;
                state_next = S_SM_RP;
            end
            S_SM_RP:
            begin
                joint_next = rd;
                raddr      = jidx_reg - IDX_W'(1);
                state_next = S_SM_WR;
            end
            S_SM_WR:
            begin
                store_wr.en     = 1'b1;
                store_wr.addr   = jidx_reg + IDX_W'(1);
                store_wr.data.x = mirror_sat(joint_reg.x, rd.x);
                store_wr.data.y = mirror_sat(joint_reg.y, rd.y);
                store_wr.data.z = mirror_sat(joint_reg.z, rd.z);
                if (i_reg == n_m1)
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    i_next     = i_reg + SEGCNT_W'(1);
                    jidx_next  = jidx_reg + IDX_W'(3);
                    state_next = S_SM_RJ;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            seg_count_reg <= SEGCNT_W'(1);
            k_reg         <= '0;
            c_reg         <= '0;
            h_reg         <= 1'b0;
            acc_en_reg    <= 1'b0;
            acc_c_reg     <= '0;
            acc_h_reg     <= 1'b0;
            res_valid_reg <= 1'b0;
            i_reg         <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            k_reg         <= k_next;
            c_reg         <= c_next;
            h_reg         <= h_next;
            acc_en_reg    <= acc_en_next;
            acc_c_reg     <= acc_c_next;
            acc_h_reg     <= acc_h_next;
            res_valid_reg <= res_valid_next;
            i_reg         <= i_next;
            if (cfg.valid && cfg.ready)
            begin
                seg_count_reg <= cfg.payload;
            end
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        t_reg     <= t_next;
        seg_reg   <= seg_next;
        base_reg  <= base_next;
        u_reg     <= u_next;
        v_reg     <= v_next;
        vv_reg    <= vv_next;
        uu_reg    <= uu_next;
        res_reg   <= res_next;
        jidx_reg  <= jidx_next;
        joint_reg <= joint_next;
        for (int n = 0; n < 4; n++)
        begin
            w_reg[n] <= w_next[n];
        end
        // Accumulators start at half an output LSB for round half up
        for (int n = 0; n < 3; n++)
        begin
            if (acc_init)
            begin
                acc_reg[n] <= ACC_ROUND;
            end
            else if (acc_en_reg && (acc_c_reg == 2'(n)))
            begin
                acc_reg[n] <= acc_reg[n] + (acc_h_reg ? (ACC_W'(prod) << 32) : ACC_W'(prod));
            end
        end
    end

    // Bernstein weights always sum to one (2^48) when blending starts
    a_weight_sum: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_MAC && k_reg == 2'd0 && c_reg == 2'd0 && !h_reg) |->
        ((51'(w_reg[0]) + 51'(w_reg[1]) + 51'(w_reg[2]) + 51'(w_reg[3]))
            == (51'(1) << 48)))
        else $error("weights do not sum to one");

    // Local parameter split is consistent and the segment is in range
    a_seg_split: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_W0) |->
        ((18'(u_reg) + 18'(v_reg) == 18'h10000) && (seg_reg < n_eff)))
        else $error("bad segment split");

    // The table is only written by a write command or a smoothing step
    a_wr_src: assert property (@(posedge clk) disable iff (!rst_n)
        store_wr.en |-> (state_reg == S_IDLE || state_reg == S_SM_WR))
        else $error("table written outside a write or smoothing step");

    // A new result appears only right after the emit step
    a_res_src: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(res_valid_reg) |-> ($past(state_reg) == S_EMIT))
        else $error("result raised outside emit");

endmodule

`default_nettype wire
